[hdl/hit_sort_and_group_buffer_top_assert.svh]
`ifndef HIT_SORT_AND_GROUP_BUFFER_TOP_ASSERT_SVH
`define HIT_SORT_AND_GROUP_BUFFER_TOP_ASSERT_SVH

// same-cycle implication
`define HSG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/hsg_pkg.sv]
package hsg_pkg;

  localparam int unsigned CapacityDefault = 256;

  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_SORT   = 3'd1,
    MODE_GROUP  = 3'd2,
    MODE_READ   = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_NONE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_ROTATE,
    CELL_SORT
  } cell_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_GROUP,
    ST_READ
  } state_e;

  // key holds entity in the upper half, material in the lower half
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] ray_id;
    logic [31:0] session_ray_id;
    logic [31:0] primitive_id;
    logic [31:0] u_bits;
    logic [31:0] v_bits;
    logic [7:0]  flags;
  } rec_t;

  typedef struct packed {
    cell_cmd_e cmd;
    logic      phase;
  } cell_ctrl_t;

  typedef struct packed {
    logic [31:0] out_ray_id;
    logic [31:0] out_session_ray_id;
    logic [31:0] out_material_id;
    logic [31:0] out_entity_id;
    logic [31:0] out_primitive_id;
    logic [31:0] out_u_bits;
    logic [31:0] out_v_bits;
    logic [7:0]  out_flags;
    logic [7:0]  group_first;
    logic [7:0]  group_final;
    status_e     status;
  } result_t;

endpackage

[hdl/hsg_if.sv]
interface hsg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] ray_id;
  logic [31:0] session_ray_id;
  logic [31:0] material_id;
  logic [31:0] entity_id;
  logic [31:0] primitive_id;
  logic [31:0] u_bits;
  logic [31:0] v_bits;
  logic [7:0]  hit_flags;
  logic [7:0]  entry_index;

  modport source (
    output valid, mode, ray_id, session_ray_id, material_id, entity_id, primitive_id,
    output u_bits, v_bits, hit_flags, entry_index,
    input  ready
  );

  modport sink (
    input  valid, mode, ray_id, session_ray_id, material_id, entity_id, primitive_id,
    input  u_bits, v_bits, hit_flags, entry_index,
    output ready
  );
endinterface

interface hsg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_ray_id;
  logic [31:0] out_session_ray_id;
  logic [31:0] out_material_id;
  logic [31:0] out_entity_id;
  logic [31:0] out_primitive_id;
  logic [31:0] out_u_bits;
  logic [31:0] out_v_bits;
  logic [7:0]  out_flags;
  logic [7:0]  group_first;
  logic [7:0]  group_final;
  logic [1:0]  status;

  modport source (
    output valid, out_ray_id, out_session_ray_id, out_material_id, out_entity_id,
    output out_primitive_id, out_u_bits, out_v_bits, out_flags, group_first,
    output group_final, status,
    input  ready
  );

  modport sink (
    input  valid, out_ray_id, out_session_ray_id, out_material_id, out_entity_id,
    input  out_primitive_id, out_u_bits, out_v_bits, out_flags, group_first,
    input  group_final, status,
    output ready
  );
endinterface

[hdl/hsg_cell.sv]
module hsg_cell #(
  parameter  int unsigned Capacity = hsg_pkg::CapacityDefault,
  parameter  int unsigned CellIdx  = 0,
  localparam int unsigned CntW     = $clog2(Capacity + 1)
) (
  input  logic                clk_i,
  input  hsg_pkg::cell_ctrl_t ctrl_i,
  input  logic [CntW-1:0]     fill_i,
  input  hsg_pkg::rec_t       load_i,
  input  hsg_pkg::rec_t       left_i,
  input  hsg_pkg::rec_t       right_i,
  output hsg_pkg::rec_t       rec_o
);

  localparam logic [CntW-1:0] IdxSelf = CntW'(CellIdx);
  localparam logic [CntW-1:0] IdxNext = CntW'(CellIdx + 1);
  localparam bit              CellOdd = (CellIdx % 2) == 1;
  localparam bit              HasLeft = CellIdx > 0;

  hsg_pkg::rec_t rec_q, rec_d;
  logic          is_left;
  logic          swap_right;
  logic          swap_left;

  always_comb begin
    is_left    = (ctrl_i.phase == CellOdd);
    swap_right = is_left && (IdxNext < fill_i) && (rec_q.key > right_i.key);
    swap_left  = !is_left && HasLeft && (IdxSelf < fill_i) && (left_i.key > rec_q.key);
    rec_d      = rec_q;
    unique case (ctrl_i.cmd)
      hsg_pkg::CELL_HOLD: begin
        rec_d = rec_q;
      end
      hsg_pkg::CELL_LOAD: begin
        if (fill_i == IdxSelf) rec_d = load_i;
      end
      hsg_pkg::CELL_ROTATE: begin
        rec_d = right_i;
      end
      hsg_pkg::CELL_SORT: begin
        if (swap_right) begin
          rec_d = right_i;
        end else if (swap_left) begin
          rec_d = left_i;
        end
      end
      default: begin
        rec_d = rec_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

[hdl/hsg_ctrl.sv]
`include "hit_sort_and_group_buffer_top_assert.svh"

module hsg_ctrl #(
  parameter  int unsigned Capacity = hsg_pkg::CapacityDefault,
  localparam int unsigned CntW     = $clog2(Capacity + 1),
  localparam int unsigned StepW    = $clog2(Capacity)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  hsg_in_if.sink              in_i,
  hsg_out_if.source           out_o,
  input  hsg_pkg::rec_t       head_i,
  output hsg_pkg::cell_ctrl_t cell_ctrl_o,
  output hsg_pkg::rec_t       load_o,
  output logic [CntW-1:0]     fill_o
);

  localparam int unsigned      CmpW     = (CntW > 8) ? CntW : 8;
  localparam logic [StepW-1:0] StepLast = StepW'(Capacity - 1);
  localparam logic [CntW-1:0]  Full     = CntW'(Capacity);

  hsg_pkg::state_e  state_q, state_d;
  hsg_pkg::result_t res_q, res_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [CntW-1:0]  cursor_q, cursor_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic [63:0]      gkey_q, gkey_d;
  logic [StepW-1:0] gfirst_q, gfirst_d;
  logic [StepW-1:0] glast_q, glast_d;
  logic             gactive_q, gactive_d;
  logic [7:0]       ridx_q, ridx_d;

  logic             in_ready;
  logic             accept;
  logic             append_ok;
  logic             last_step;
  logic             group_ok;
  logic             read_ok;
  logic [CntW-1:0]  step_cnt;

  assign in_ready  = (state_q == hsg_pkg::ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept    = in_i.valid && in_ready;
  assign last_step = (step_q == StepLast);
  assign group_ok  = (cursor_q < fill_q);
  assign read_ok   = (CmpW'(in_i.entry_index) < CmpW'(fill_q));
  assign step_cnt  = CntW'(step_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hsg_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_i.mode)
            hsg_pkg::MODE_SORT:  state_d = hsg_pkg::ST_SORT;
            hsg_pkg::MODE_GROUP: if (group_ok) state_d = hsg_pkg::ST_GROUP;
            hsg_pkg::MODE_READ:  if (read_ok) state_d = hsg_pkg::ST_READ;
            default:             state_d = hsg_pkg::ST_IDLE;
          endcase
        end
      end
      hsg_pkg::ST_SORT, hsg_pkg::ST_GROUP, hsg_pkg::ST_READ: begin
        if (last_step) state_d = hsg_pkg::ST_IDLE;
      end
      default: state_d = hsg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    fill_d      = fill_q;
    cursor_d    = cursor_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_o.ready;
    res_d       = res_q;
    gkey_d      = gkey_q;
    gfirst_d    = gfirst_q;
    glast_d     = glast_q;
    gactive_d   = gactive_q;
    ridx_d      = ridx_q;
    append_ok   = 1'b0;

    cell_ctrl_o.cmd   = hsg_pkg::CELL_HOLD;
    cell_ctrl_o.phase = step_q[0];

    load_o.key            = {in_i.entity_id, in_i.material_id};
    load_o.ray_id         = in_i.ray_id;
    load_o.session_ray_id = in_i.session_ray_id;
    load_o.primitive_id   = in_i.primitive_id;
    load_o.u_bits         = in_i.u_bits;
    load_o.v_bits         = in_i.v_bits;
    load_o.flags          = in_i.hit_flags;

    unique case (state_q)
      hsg_pkg::ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          unique case (in_i.mode)
            hsg_pkg::MODE_APPEND: begin
              if (fill_q == Full) begin
                res_d.status = hsg_pkg::STATUS_FULL;
              end else begin
                append_ok       = 1'b1;
                cell_ctrl_o.cmd = hsg_pkg::CELL_LOAD;
                fill_d          = fill_q + CntW'(1);
              end
              out_valid_d = 1'b1;
            end
            hsg_pkg::MODE_SORT: begin
              step_d = '0;
            end
            hsg_pkg::MODE_GROUP: begin
              if (group_ok) begin
                gactive_d = 1'b0;
              end else begin
                res_d.status = hsg_pkg::STATUS_NONE;
                out_valid_d  = 1'b1;
              end
            end
            hsg_pkg::MODE_READ: begin
              if (read_ok) begin
                ridx_d = in_i.entry_index;
              end else begin
                res_d.status = hsg_pkg::STATUS_NONE;
                out_valid_d  = 1'b1;
              end
            end
            hsg_pkg::MODE_CLEAR: begin
              fill_d      = '0;
              cursor_d    = '0;
              out_valid_d = 1'b1;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      hsg_pkg::ST_SORT: begin
        cell_ctrl_o.cmd = hsg_pkg::CELL_SORT;
        step_d          = last_step ? '0 : step_q + StepW'(1);
        if (last_step) begin
          res_d       = '0;
          cursor_d    = '0;
          out_valid_d = 1'b1;
        end
      end
      hsg_pkg::ST_GROUP: begin
        cell_ctrl_o.cmd = hsg_pkg::CELL_ROTATE;
        step_d          = last_step ? '0 : step_q + StepW'(1);
        if (step_cnt == cursor_q) begin
          gkey_d    = head_i.key;
          gfirst_d  = step_q;
          glast_d   = step_q;
          gactive_d = 1'b1;
        end else if (gactive_q) begin
          if ((step_cnt < fill_q) && (head_i.key == gkey_q)) begin
            glast_d = step_q;
          end else begin
            gactive_d = 1'b0;
          end
        end
        if (last_step) begin
          res_d                 = '0;
          res_d.out_entity_id   = gkey_d[63:32];
          res_d.out_material_id = gkey_d[31:0];
          res_d.group_first     = 8'(gfirst_d);
          res_d.group_final     = 8'(glast_d);
          cursor_d              = CntW'(glast_d) + CntW'(1);
          out_valid_d           = 1'b1;
        end
      end
      hsg_pkg::ST_READ: begin
        cell_ctrl_o.cmd = hsg_pkg::CELL_ROTATE;
        step_d          = last_step ? '0 : step_q + StepW'(1);
        if (CmpW'(step_q) == CmpW'(ridx_q)) begin
          res_d                    = '0;
          res_d.out_ray_id         = head_i.ray_id;
          res_d.out_session_ray_id = head_i.session_ray_id;
          res_d.out_entity_id      = head_i.key[63:32];
          res_d.out_material_id    = head_i.key[31:0];
          res_d.out_primitive_id   = head_i.primitive_id;
          res_d.out_u_bits         = head_i.u_bits;
          res_d.out_v_bits         = head_i.v_bits;
          res_d.out_flags          = head_i.flags;
        end
        if (last_step) out_valid_d = 1'b1;
      end
      default: begin
        step_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hsg_pkg::ST_IDLE;
      fill_q      <= '0;
      cursor_q    <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      gactive_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cursor_q    <= cursor_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      gactive_q   <= gactive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    gkey_q   <= gkey_d;
    gfirst_q <= gfirst_d;
    glast_q  <= glast_d;
    ridx_q   <= ridx_d;
  end

  assign fill_o                   = fill_q;
  assign in_i.ready               = in_ready;
  assign out_o.valid              = out_valid_q;
  assign out_o.out_ray_id         = res_q.out_ray_id;
  assign out_o.out_session_ray_id = res_q.out_session_ray_id;
  assign out_o.out_material_id    = res_q.out_material_id;
  assign out_o.out_entity_id      = res_q.out_entity_id;
  assign out_o.out_primitive_id   = res_q.out_primitive_id;
  assign out_o.out_u_bits         = res_q.out_u_bits;
  assign out_o.out_v_bits         = res_q.out_v_bits;
  assign out_o.out_flags          = res_q.out_flags;
  assign out_o.group_first        = res_q.group_first;
  assign out_o.group_final        = res_q.group_final;
  assign out_o.status             = res_q.status;

  `HSG_ASSERT_IMP(a_fill_cap, clk_i, rst_ni, 1'b1, fill_q <= Full, "fill count above capacity")
  `HSG_ASSERT_IMP(a_cursor_fill, clk_i, rst_ni, 1'b1, cursor_q <= fill_q, "group cursor past fill")
  `HSG_ASSERT_NXT(a_busy_done, clk_i, rst_ni, state_q != hsg_pkg::ST_IDLE && last_step, out_valid_q, "no result after ring pass")
  `HSG_ASSERT_NXT(a_append_grow, clk_i, rst_ni, append_ok, fill_q == $past(fill_q) + CntW'(1), "append did not advance fill")

endmodule

[hdl/hit_sort_and_group_buffer_top.sv]
// Hit sort-and-group buffer: a ring of Capacity record cells, one item at a time. Append, clear,
// an out-of-range read, an exhausted group search and an undefined mode finish straight into
// the output register. Sort, next group and an in-range read first make a pass over the ring:
// sort runs Capacity rounds of odd-even neighbor compare-and-swap over the held records, and
// group and read rotate the ring once around so every record passes cell 0, where it is
// inspected. A new item is taken once the previous result is gone or leaves in the same cycle.
module hit_sort_and_group_buffer_top #(
  parameter int unsigned Capacity = hsg_pkg::CapacityDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsg_in_if.sink    in_i,
  hsg_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  hsg_pkg::rec_t       rec_w [Capacity];
  hsg_pkg::rec_t       load_w;
  hsg_pkg::cell_ctrl_t cell_ctrl_w;
  logic [CntW-1:0]     fill_w;

  hsg_ctrl #(
    .Capacity(Capacity)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .head_i      (rec_w[0]),
    .cell_ctrl_o (cell_ctrl_w),
    .load_o      (load_w),
    .fill_o      (fill_w)
  );

  for (genvar gi = 0; gi < Capacity; gi++) begin : g_cell
    hsg_cell #(
      .Capacity(Capacity),
      .CellIdx (gi)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl_w),
      .fill_i  (fill_w),
      .load_i  (load_w),
      .left_i  (rec_w[(gi + Capacity - 1) % Capacity]),
      .right_i (rec_w[(gi + 1) % Capacity]),
      .rec_o   (rec_w[gi])
    );
  end

endmodule

[dv/hit_sort_and_group_buffer_top_test.sv]
`timescale 1ns / 1ps

module hit_sort_and_group_buffer_top_test;

  localparam int unsigned Capacity       = hsg_pkg::CapacityDefault;
  localparam int unsigned StallLimit     = 4000;
  localparam int unsigned SinkHoldCycles = 400;
  localparam int unsigned TailCycles     = Capacity + 10;
  localparam int unsigned RandomOps      = 1600;

  localparam logic [2:0] MODE_RSVD_A = 3'd5;
  localparam logic [2:0] MODE_RSVD_B = 3'd6;
  localparam logic [2:0] MODE_RSVD_C = 3'd7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] ray_id;
    logic [31:0] session_ray_id;
    logic [31:0] material_id;
    logic [31:0] entity_id;
    logic [31:0] primitive_id;
    logic [31:0] u_bits;
    logic [31:0] v_bits;
    logic [7:0]  hit_flags;
    logic [7:0]  entry_index;
  } hit_req_t;

  typedef struct {
    hit_req_t          req;
    bit                has_exp;
    hsg_pkg::result_t  exp;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hsg_in_if  in_if ();
  hsg_out_if out_if ();

  hit_sort_and_group_buffer_top #(.Capacity(Capacity)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  hsg_pkg::rec_t    shadow_recs [Capacity];
  int unsigned      shadow_fill;
  int unsigned      shadow_cursor;

  hsg_pkg::result_t op_results_q [$];
  int unsigned      mismatch_cnt;
  int unsigned      result_cnt;
  int unsigned      idle_cycles;
  int unsigned      sent_ops;
  int unsigned      src_idle_pct;
  int unsigned      sink_idle_pct;
  int unsigned      sink_hold_reqs;
  int unsigned      sink_holds_done;

  function automatic hsg_pkg::result_t run_hit_op(input hit_req_t r);
    hsg_pkg::result_t res;
    hsg_pkg::rec_t    held;
    logic [63:0]      run_key;
    int unsigned      i;
    int unsigned      j;
    int unsigned      pos;
    res = '0;
    res.status = hsg_pkg::STATUS_OK;
    case (r.mode)
      hsg_pkg::MODE_APPEND: begin
        if (shadow_fill >= Capacity) begin
          res.status = hsg_pkg::STATUS_FULL;
        end else begin
          shadow_recs[shadow_fill] = '{key: {r.entity_id, r.material_id},
                                       ray_id: r.ray_id,
                                       session_ray_id: r.session_ray_id,
                                       primitive_id: r.primitive_id,
                                       u_bits: r.u_bits,
                                       v_bits: r.v_bits,
                                       flags: r.hit_flags};
          shadow_fill++;
        end
      end
      hsg_pkg::MODE_SORT: begin
        for (i = 1; i < shadow_fill; i++) begin
          held = shadow_recs[i];
          j = i;
          while (j > 0 && shadow_recs[j-1].key > held.key) begin
            shadow_recs[j] = shadow_recs[j-1];
            j--;
          end
          shadow_recs[j] = held;
        end
        shadow_cursor = 0;
      end
      hsg_pkg::MODE_GROUP: begin
        if (shadow_cursor >= shadow_fill) begin
          res.status = hsg_pkg::STATUS_NONE;
        end else begin
          run_key = shadow_recs[shadow_cursor].key;
          pos = shadow_cursor;
          while (pos < shadow_fill && shadow_recs[pos].key == run_key) pos++;
          res.out_material_id = run_key[31:0];
          res.out_entity_id   = run_key[63:32];
          res.group_first     = 8'(shadow_cursor);
          res.group_final     = 8'(pos - 1);
          shadow_cursor = pos;
        end
      end
      hsg_pkg::MODE_READ: begin
        if (r.entry_index >= shadow_fill) begin
          res.status = hsg_pkg::STATUS_NONE;
        end else begin
          held = shadow_recs[r.entry_index];
          res.out_ray_id         = held.ray_id;
          res.out_session_ray_id = held.session_ray_id;
          res.out_material_id    = held.key[31:0];
          res.out_entity_id      = held.key[63:32];
          res.out_primitive_id   = held.primitive_id;
          res.out_u_bits         = held.u_bits;
          res.out_v_bits         = held.v_bits;
          res.out_flags          = held.flags;
        end
      end
      hsg_pkg::MODE_CLEAR: begin
        shadow_fill   = 0;
        shadow_cursor = 0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic hit_req_t hit_op(input logic [2:0] mode, input logic [31:0] ent,
                                      input logic [31:0] mat, input logic [31:0] fill,
                                      input logic [7:0] idx);
    hit_req_t r;
    r.mode           = mode;
    r.ray_id         = fill;
    r.session_ray_id = ~fill;
    r.material_id    = mat;
    r.entity_id      = ent;
    r.primitive_id   = fill;
    r.u_bits         = fill;
    r.v_bits         = ~fill;
    r.hit_flags      = fill[7:0];
    r.entry_index    = idx;
    return r;
  endfunction

  function automatic hit_req_t rand_hit();
    hit_req_t r;
    r.mode           = 3'($urandom_range(MODE_RSVD_C));
    r.ray_id         = $urandom;
    r.session_ray_id = $urandom;
    r.material_id    = $urandom;
    r.entity_id      = $urandom;
    r.primitive_id   = $urandom;
    r.u_bits         = $urandom;
    r.v_bits         = $urandom;
    r.hit_flags      = 8'($urandom);
    r.entry_index    = 8'($urandom);
    return r;
  endfunction

  function automatic hsg_pkg::result_t status_only(input hsg_pkg::status_e s);
    hsg_pkg::result_t res;
    res = '0;
    res.status = s;
    return res;
  endfunction

  task automatic send_hit(input hit_req_t r, input bit has_exp, input hsg_pkg::result_t exp);
    hsg_pkg::result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.mode           <= r.mode;
    in_if.ray_id         <= r.ray_id;
    in_if.session_ray_id <= r.session_ray_id;
    in_if.material_id    <= r.material_id;
    in_if.entity_id      <= r.entity_id;
    in_if.primitive_id   <= r.primitive_id;
    in_if.u_bits         <= r.u_bits;
    in_if.v_bits         <= r.v_bits;
    in_if.hit_flags      <= r.hit_flags;
    in_if.entry_index    <= r.entry_index;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    res = run_hit_op(r);
    op_results_q.push_back(has_exp ? exp : res);
    if (r.mode <= hsg_pkg::MODE_CLEAR) sent_ops++;
  endtask

  task automatic send_mode(input logic [2:0] mode, input logic [7:0] idx);
    hit_req_t r;
    r = rand_hit();
    r.mode = mode;
    r.entry_index = idx;
    send_hit(r, 1'b0, '0);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (op_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_session(input int unsigned n_recs, input bit hold_sink);
    logic [31:0] ents [3];
    logic [31:0] mats [3];
    bit          wide_keys;
    hit_req_t    r;
    int unsigned k;
    wide_keys = (n_recs < 64) && ($urandom_range(3) == 0);
    for (k = 0; k < 3; k++) begin
      ents[k] = $urandom;
      mats[k] = $urandom;
    end
    if ($urandom_range(1) == 0) ents[0] = '0;
    if ($urandom_range(1) == 0) mats[2] = '1;
    if ($urandom_range(7) != 0) send_mode(hsg_pkg::MODE_CLEAR, '0);
    if (hold_sink) sink_hold_reqs++;
    repeat (n_recs) begin
      r = rand_hit();
      r.mode = hsg_pkg::MODE_APPEND;
      if (!wide_keys) begin
        r.entity_id   = ents[$urandom_range(2)];
        r.material_id = mats[$urandom_range(2)];
      end
      send_hit(r, 1'b0, '0);
    end
    if ($urandom_range(5) == 0) send_mode(hsg_pkg::MODE_GROUP, '0);
    if ($urandom_range(5) != 0) send_mode(hsg_pkg::MODE_SORT, '0);
    while (shadow_cursor < shadow_fill) send_mode(hsg_pkg::MODE_GROUP, '0);
    send_mode(hsg_pkg::MODE_GROUP, '0);
    if (shadow_fill != 0) begin
      send_mode(hsg_pkg::MODE_READ, '0);
      send_mode(hsg_pkg::MODE_READ, 8'(shadow_fill - 1));
      repeat ($urandom_range(3))
        send_mode(hsg_pkg::MODE_READ, 8'($urandom_range(shadow_fill - 1)));
    end
    if (shadow_fill < Capacity)
      send_mode(hsg_pkg::MODE_READ, 8'($urandom_range(255, shadow_fill)));
    if ($urandom_range(3) == 0 && shadow_fill < Capacity) begin
      send_mode(hsg_pkg::MODE_APPEND, '0);
      send_mode(hsg_pkg::MODE_READ, 8'(shadow_fill - 1));
    end
  endtask

  always @(posedge clk_i) begin : check_results
    hsg_pkg::result_t got;
    hsg_pkg::result_t exp;
    if (out_if.valid && out_if.ready) begin
      got.out_ray_id         = out_if.out_ray_id;
      got.out_session_ray_id = out_if.out_session_ray_id;
      got.out_material_id    = out_if.out_material_id;
      got.out_entity_id      = out_if.out_entity_id;
      got.out_primitive_id   = out_if.out_primitive_id;
      got.out_u_bits         = out_if.out_u_bits;
      got.out_v_bits         = out_if.out_v_bits;
      got.out_flags          = out_if.out_flags;
      got.group_first        = out_if.group_first;
      got.group_final        = out_if.group_final;
      got.status             = hsg_pkg::status_e'(out_if.status);
      result_cnt++;
      if (op_results_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("result %0d arrived with none pending", result_cnt);
      end else begin
        exp = op_results_q.pop_front();
        if (got !== exp) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("result %0d differs", result_cnt);
            $display("  exp ray %h ses %h mat %h ent %h pri %h u %h v %h f %h g %h..%h st %0d",
                     exp.out_ray_id, exp.out_session_ray_id, exp.out_material_id,
                     exp.out_entity_id, exp.out_primitive_id, exp.out_u_bits,
                     exp.out_v_bits, exp.out_flags, exp.group_first, exp.group_final,
                     exp.status);
            $display("  got ray %h ses %h mat %h ent %h pri %h u %h v %h f %h g %h..%h st %0d",
                     got.out_ray_id, got.out_session_ray_id, got.out_material_id,
                     got.out_entity_id, got.out_primitive_id, got.out_u_bits,
                     got.out_v_bits, got.out_flags, got.group_first, got.group_final,
                     got.status);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_reqs != sink_holds_done) begin
        sink_holds_done++;
        out_if.ready <= 1'b0;
        repeat (SinkHoldCycles) @(posedge clk_i);
      end
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin : stimulus
    dir_row_t         dir_rows [$];
    hsg_pkg::result_t ones_read;
    int unsigned      phase;
    int unsigned      phase_goal;
    bit               first_session;
    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.mode           <= hsg_pkg::MODE_APPEND;
    in_if.ray_id         <= '0;
    in_if.session_ray_id <= '0;
    in_if.material_id    <= '0;
    in_if.entity_id      <= '0;
    in_if.primitive_id   <= '0;
    in_if.u_bits         <= '0;
    in_if.v_bits         <= '0;
    in_if.hit_flags      <= '0;
    in_if.entry_index    <= '0;
    sent_ops       = 0;
    src_idle_pct   = 15;
    sink_idle_pct  = 45;
    sink_hold_reqs = 0;
    shadow_fill    = 0;
    shadow_cursor  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ones_read = '1;
    ones_read.out_session_ray_id = '0;
    ones_read.out_v_bits         = '0;
    ones_read.group_first        = '0;
    ones_read.group_final        = '0;
    ones_read.status             = hsg_pkg::STATUS_OK;
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_READ, '0, '0, '0, '0), 1'b1,
                         status_only(hsg_pkg::STATUS_NONE)});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_GROUP, '0, '0, '0, '0), 1'b1,
                         status_only(hsg_pkg::STATUS_NONE)});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_SORT, '0, '0, '0, '0), 1'b1,
                         status_only(hsg_pkg::STATUS_OK)});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_APPEND, '1, '1, '1, '1), 1'b1,
                         status_only(hsg_pkg::STATUS_OK)});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_APPEND, '0, '0, '0, '0), 1'b1,
                         status_only(hsg_pkg::STATUS_OK)});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_APPEND, '0, '1, 32'h5a5a5a5a, '0), 1'b1,
                         status_only(hsg_pkg::STATUS_OK)});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_APPEND, '0, '0, 32'ha5a5a5a5, '0), 1'b1,
                         status_only(hsg_pkg::STATUS_OK)});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_APPEND, '1, '0, 32'h3c3c3c3c, '0), 1'b1,
                         status_only(hsg_pkg::STATUS_OK)});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_READ, '0, '0, '0, 8'd0), 1'b1, ones_read});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_READ, '0, '0, '0, 8'd5), 1'b1,
                         status_only(hsg_pkg::STATUS_NONE)});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_READ, '0, '0, '0, '1), 1'b1,
                         status_only(hsg_pkg::STATUS_NONE)});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_GROUP, '0, '0, '0, '0), 1'b0, '0});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_SORT, '0, '0, '0, '0), 1'b1,
                         status_only(hsg_pkg::STATUS_OK)});
    repeat (5) dir_rows.push_back('{hit_op(hsg_pkg::MODE_GROUP, '0, '0, '0, '0), 1'b0, '0});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_READ, '0, '0, '0, 8'd1), 1'b0, '0});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_READ, '0, '0, '0, 8'd4), 1'b0, '0});
    dir_rows.push_back('{hit_op(MODE_RSVD_A, '1, '1, '1, '1), 1'b1,
                         status_only(hsg_pkg::STATUS_OK)});
    dir_rows.push_back('{hit_op(MODE_RSVD_C, '1, '1, '1, '1), 1'b1,
                         status_only(hsg_pkg::STATUS_OK)});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_APPEND, 32'd1, 32'd1, 32'h0f0f0f0f, '0), 1'b1,
                         status_only(hsg_pkg::STATUS_OK)});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_CLEAR, '0, '0, '0, '0), 1'b1,
                         status_only(hsg_pkg::STATUS_OK)});
    dir_rows.push_back('{hit_op(hsg_pkg::MODE_READ, '0, '0, '0, '0), 1'b1,
                         status_only(hsg_pkg::STATUS_NONE)});
    foreach (dir_rows[k]) send_hit(dir_rows[k].req, dir_rows[k].has_exp, dir_rows[k].exp);

    for (phase = 0; phase < 3; phase++) begin
      drain_results();
      case (phase)
        0: begin
          src_idle_pct  = 15;
          sink_idle_pct = 45;
        end
        1: begin
          src_idle_pct  = 45;
          sink_idle_pct = 15;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      phase_goal = sent_ops + RandomOps / 3;
      first_session = 1'b1;
      while (sent_ops < phase_goal) begin
        if (first_session && phase == 0) begin
          run_session(40, 1'b1);
        end else if (first_session && phase == 2) begin
          run_session(Capacity + 2, 1'b0);
        end else if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(3, 12)) send_hit(rand_hit(), 1'b0, '0);
        end else if ($urandom_range(9) == 0) begin
          run_session($urandom_range(30, 80), 1'b0);
        end else begin
          run_session($urandom_range(20), 1'b0);
        end
        first_session = 1'b0;
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && op_results_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[hit_sort_and_group_buffer_top.f]
+incdir+hdl
hdl/hsg_pkg.sv
hdl/hsg_if.sv
hdl/hsg_cell.sv
hdl/hsg_ctrl.sv
hdl/hit_sort_and_group_buffer_top.sv
dv/hit_sort_and_group_buffer_top_test.sv
